FILE: design/stack_top_register_cache_assert.svh
// Assertion macros used by the stack cache RTL.
`ifndef STACK_TOP_REGISTER_CACHE_ASSERT_SVH
`define STACK_TOP_REGISTER_CACHE_ASSERT_SVH
`ifndef SYNTHESIS
`define STC_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define STC_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define STC_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define STC_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

FILE: design/stc_pkg.sv
`default_nettype none
package stc_pkg;
    localparam int CacheSlots  = 8;
    localparam int StackWords  = 256;
    localparam int SpillMark   = 4;
    localparam int RefillMark  = 6;
    localparam int WordBits    = 32;

    typedef enum logic [2:0] {
        K_PUSH  = 3'd0,
        K_POP   = 3'd1,
        K_NOP   = 3'd2,
        K_READ  = 3'd3,
        K_WRITE = 3'd4,
        K_MOVE  = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_NOT_HELD  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FLUSH,
        S_EXEC,
        S_STEP,
        S_FILL_WAIT,
        S_OUT
    } t_state;
endpackage
`default_nettype wire

FILE: design/stc_ram.sv
`default_nettype none
module stc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

FILE: design/stack_top_register_cache.sv
// Stack-top register cache.
// Input channel (i_valid/o_stall) takes one operation per beat: push, pop,
// nop, read, write or move. Output channel (o_valid/i_stall) returns one
// result beat per operation: read word, top word, depth, held count, status.
// Slot state lives in registers; words below the cached top live in a
// single-port backing RAM with a registered read port.
// Read, write, move and unknown kinds pass through S_EXEC to S_OUT; push,
// pop and nop pass through S_EXEC and S_STEP, plus S_FILL_WAIT when a refill
// reads the RAM. A push that hits a dirty bottom slot first writes back every
// dirty slot in S_FLUSH, one RAM write per cycle, then returns to S_EXEC once
// no dirty slot is left and redoes the push.
// One operation is in flight at a time; o_stall stays high until its result
// beat has been taken, and the next beat is accepted at the edge after that.
// While i_stall is high the result holds.
// Reset empties all slots and clears the spill and refill engine; the
// backing RAM is not cleared and needs no pass.
`default_nettype none
`include "stack_top_register_cache_assert.svh"
module stack_top_register_cache #(
    parameter int CACHE_SLOTS = stc_pkg::CacheSlots,
    parameter int STACK_WORDS = stc_pkg::StackWords,
    parameter int SPILL_MARK  = stc_pkg::SpillMark,
    parameter int REFILL_MARK = stc_pkg::RefillMark,
    parameter int WORD_BITS   = stc_pkg::WordBits
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_kind,
    input  wire logic [31:0] i_value,
    input  wire logic [2:0]  i_reg_sel,
    input  wire logic [2:0]  i_reg_src,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_read_value,
    output logic [31:0]      o_top_value,
    output logic [8:0]       o_depth,
    output logic [3:0]       o_held,
    output logic [1:0]       o_status
);
    localparam int SW = $clog2(CACHE_SLOTS);
    localparam int MW = $clog2(CACHE_SLOTS + 1);
    localparam int AW = $clog2(STACK_WORDS);
    localparam int CW = $clog2(STACK_WORDS + 1);
    localparam logic [MW-1:0] EMPTY = MW'(CACHE_SLOTS);
    localparam logic [MW-1:0] FULL  = MW'(CACHE_SLOTS);

    // slot state
    logic [WORD_BITS-1:0] r_word  [CACHE_SLOTS];
    logic [CACHE_SLOTS-1:0] r_live, r_clean;
    logic [AW-1:0]        r_home  [CACHE_SLOTS];
    logic [MW-1:0]        r_order [CACHE_SLOTS];
    logic [MW-1:0]        r_held;
    logic [CW-1:0]        r_count;
    logic [MW-1:0]        r_cursor;
    logic                 r_cursor_none, r_spill, r_refill;

    stc_pkg::t_state r_state, n_state;
    logic [2:0]  r_kind;
    logic [31:0] r_value, r_rd;
    logic [2:0]  r_sel, r_src;
    logic [1:0]  r_status;
    logic        r_outv;
    logic [SW-1:0] r_fill_slot;

    // RAM port
    logic                 m_we;
    logic [AW-1:0]        m_addr;
    logic [WORD_BITS-1:0] m_wdata, m_rdata;

    stc_ram #(.WIDTH(WORD_BITS), .DEPTH(STACK_WORDS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (m_we),
        .i_addr (m_addr),
        .i_wdata(m_wdata),
        .o_rdata(m_rdata)
    );

    // first dirty live slot, for flush
    logic          dirty_any;
    logic [SW-1:0] dirty_idx;
    always_comb begin
        dirty_any = 1'b0;
        dirty_idx = '0;
        for (int i = CACHE_SLOTS - 1; i >= 0; i--) begin
            if (r_live[i] && !r_clean[i]) begin
                dirty_any = 1'b1;
                dirty_idx = SW'(i);
            end
        end
    end

    // free slot search as in the model: above held first, then from zero
    logic [SW-1:0] free_idx;
    always_comb begin
        logic found;
        found = 1'b0;
        free_idx = '0;
        for (int i = 0; i < CACHE_SLOTS; i++) begin
            if (!found && MW'(i) > r_held && !r_live[i]) begin
                found = 1'b1;
                free_idx = SW'(i);
            end
        end
        for (int i = 0; i < CACHE_SLOTS; i++) begin
            if (!found && MW'(i) <= r_held && !r_live[i]) begin
                found = 1'b1;
                free_idx = SW'(i);
            end
        end
    end

    // spill scan: highest depth <= start below held with dirty slot
    logic [MW-1:0] sp_start;
    logic          sp_found;
    logic [MW-1:0] sp_depth;
    always_comb begin
        sp_start = r_cursor_none ? (r_held - 1'b1) : r_cursor;
        sp_found = 1'b0;
        sp_depth = '0;
        for (int i = 0; i < CACHE_SLOTS; i++) begin
            if (r_held != '0 && MW'(i) <= sp_start && MW'(i) < r_held &&
                r_order[i] != EMPTY && r_live[r_order[i][SW-1:0]] &&
                !r_clean[r_order[i][SW-1:0]]) begin
                sp_found = 1'b1;
                sp_depth = MW'(i);
            end
        end
    end

    // slot lookup by depth
    logic          sel_ok, src_ok;
    logic [SW-1:0] sel_slot, src_slot;
    always_comb begin
        sel_ok = MW'(r_sel) < r_held && 32'(r_sel) < CACHE_SLOTS;
        src_ok = MW'(r_src) < r_held && 32'(r_src) < CACHE_SLOTS;
        sel_slot = '0;
        src_slot = '0;
        if (sel_ok) begin
            sel_ok = r_order[r_sel[SW-1:0]] != EMPTY;
            sel_slot = r_order[r_sel[SW-1:0]][SW-1:0];
        end
        if (src_ok) begin
            src_ok = r_order[r_src[SW-1:0]] != EMPTY;
            src_slot = r_order[r_src[SW-1:0]][SW-1:0];
        end
    end

    logic [MW-1:0] bottom;
    logic          need_flush;
    assign bottom = r_order[CACHE_SLOTS-1];
    assign need_flush = bottom != EMPTY && !r_clean[bottom[SW-1:0]];

    logic refill_go;
    logic [CW-1:0] fill_home;
    assign refill_go = r_held < FULL && r_count > CW'(r_held);
    assign fill_home = r_count - CW'(r_held) - 1'b1;

    // overflow and underflow leave the engine alone
    logic step_ok;
    assign step_ok = r_status == stc_pkg::ST_OK || r_kind == stc_pkg::K_NOP;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            stc_pkg::S_IDLE: if (i_valid) n_state = stc_pkg::S_EXEC;
            stc_pkg::S_EXEC: begin
                if (r_kind == stc_pkg::K_PUSH && 32'(r_count) < STACK_WORDS && need_flush)
                    n_state = stc_pkg::S_FLUSH;
                else if (r_kind == stc_pkg::K_PUSH || r_kind == stc_pkg::K_POP ||
                         r_kind == stc_pkg::K_NOP)
                    n_state = stc_pkg::S_STEP;
                else
                    n_state = stc_pkg::S_OUT;
            end
            stc_pkg::S_FLUSH: if (!dirty_any) n_state = stc_pkg::S_EXEC;
            stc_pkg::S_STEP: begin
                if (step_ok && r_refill && refill_go) n_state = stc_pkg::S_FILL_WAIT;
                else n_state = stc_pkg::S_OUT;
            end
            stc_pkg::S_FILL_WAIT: n_state = stc_pkg::S_OUT;
            stc_pkg::S_OUT: if (!i_stall) n_state = stc_pkg::S_IDLE;
            default: n_state = stc_pkg::S_IDLE;
        endcase
    end

    // RAM drive
    always_comb begin
        m_we = 1'b0;
        m_addr = '0;
        m_wdata = '0;
        case (r_state)
            stc_pkg::S_FLUSH: begin
                m_we = dirty_any;
                m_addr = r_home[dirty_idx];
                m_wdata = r_word[dirty_idx];
            end
            stc_pkg::S_STEP: begin
                if (step_ok) begin
                    if (r_refill) begin
                        m_addr = fill_home[AW-1:0];
                    end else if (r_spill && sp_found) begin
                        m_we = 1'b1;
                        m_addr = r_home[r_order[sp_depth[SW-1:0]][SW-1:0]];
                        m_wdata = r_word[r_order[sp_depth[SW-1:0]][SW-1:0]];
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_stall = r_state != stc_pkg::S_IDLE;
    assign o_valid = r_outv;
    assign o_read_value = r_rd;
    assign o_status = r_status;
    assign o_depth = 9'(r_count);
    assign o_held = 4'(r_held);
    assign o_top_value = (r_held != '0 && r_order[0] != EMPTY) ?
                         32'(r_word[r_order[0][SW-1:0]]) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stc_pkg::S_IDLE;
            r_outv <= 1'b0;
            r_live <= '0;
            r_clean <= '0;
            r_held <= '0;
            r_count <= '0;
            r_cursor <= '0;
            r_cursor_none <= 1'b1;
            r_spill <= 1'b0;
            r_refill <= 1'b0;
            for (int i = 0; i < CACHE_SLOTS; i++) begin
                r_order[i] <= EMPTY;
                r_word[i] <= '0;
                r_home[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            case (r_state)
                stc_pkg::S_IDLE: begin
                    if (i_valid) begin
                        r_kind <= i_kind;
                        r_value <= i_value;
                        r_sel <= i_reg_sel;
                        r_src <= i_reg_src;
                    end
                end
                stc_pkg::S_FLUSH: begin
                    if (dirty_any) r_clean[dirty_idx] <= 1'b1;
                end
                stc_pkg::S_EXEC: begin
                    r_status <= stc_pkg::ST_OK;
                    r_rd <= '0;
                    case (r_kind)
                        stc_pkg::K_PUSH: begin
                            if (32'(r_count) >= STACK_WORDS) begin
                                r_status <= stc_pkg::ST_OVERFLOW;
                            end else if (!need_flush) begin
                                logic [SW-1:0] fr;
                                if (SPILL_MARK < CACHE_SLOTS &&
                                    r_order[SPILL_MARK % CACHE_SLOTS] != EMPTY) begin
                                    r_spill <= 1'b1;
                                    r_refill <= 1'b0;
                                end
                                if (r_held >= FULL) begin
                                    fr = (bottom != EMPTY) ? bottom[SW-1:0] : '0;
                                end else begin
                                    fr = free_idx;
                                    r_held <= r_held + 1'b1;
                                end
                                for (int i = 1; i < CACHE_SLOTS; i++) begin
                                    if (MW'(i) <= r_held || r_held >= FULL)
                                        r_order[i] <= r_order[i-1];
                                end
                                r_order[0] <= MW'(fr);
                                r_home[fr] <= r_count[AW-1:0];
                                r_count <= r_count + 1'b1;
                                r_word[fr] <= WORD_BITS'(r_value);
                                r_clean[fr] <= 1'b0;
                                r_live[fr] <= 1'b1;
                            end
                        end
                        stc_pkg::K_POP: begin
                            if (r_count == '0 || r_held == '0) begin
                                r_status <= stc_pkg::ST_UNDERFLOW;
                            end else begin
                                logic [MW-1:0] nh;
                                logic nref, nsp;
                                nh = r_held - 1'b1;
                                for (int i = 0; i + 1 < CACHE_SLOTS; i++) begin
                                    if (MW'(i + 1) < r_held)
                                        r_order[i] <= r_order[i+1];
                                end
                                r_order[nh[SW-1:0]] <= EMPTY;
                                r_held <= nh;
                                r_count <= r_count - 1'b1;
                                nref = r_refill;
                                nsp = r_spill;
                                if (32'(nh) <= REFILL_MARK &&
                                    (r_count - 1'b1) != CW'(nh)) begin
                                    nref = 1'b1;
                                    nsp = 1'b0;
                                end
                                r_refill <= nref;
                                r_spill <= nsp;
                                if (nsp) begin
                                    r_cursor_none <= nh == '0;
                                    r_cursor <= nh - 1'b1;
                                end
                                if (r_order[0] != EMPTY) begin
                                    r_live[r_order[0][SW-1:0]] <= 1'b0;
                                    r_clean[r_order[0][SW-1:0]] <= 1'b0;
                                end
                            end
                        end
                        stc_pkg::K_READ: begin
                            if (!sel_ok) r_status <= stc_pkg::ST_NOT_HELD;
                            else r_rd <= 32'(r_word[sel_slot]);
                        end
                        stc_pkg::K_WRITE: begin
                            if (!sel_ok) begin
                                r_status <= stc_pkg::ST_NOT_HELD;
                            end else begin
                                r_word[sel_slot] <= WORD_BITS'(r_value);
                                r_clean[sel_slot] <= 1'b0;
                                r_live[sel_slot] <= 1'b1;
                            end
                        end
                        stc_pkg::K_MOVE: begin
                            if (!sel_ok || !src_ok) begin
                                r_status <= stc_pkg::ST_NOT_HELD;
                            end else begin
                                r_word[sel_slot] <= r_word[src_slot];
                                r_clean[sel_slot] <= 1'b0;
                                r_live[sel_slot] <= 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                stc_pkg::S_STEP: begin
                    if (step_ok) begin
                        if (r_refill) begin
                            if (!refill_go) begin
                                r_refill <= 1'b0;
                            end else begin
                                r_fill_slot <= free_idx;
                                r_live[free_idx] <= 1'b1;
                                r_clean[free_idx] <= 1'b1;
                                r_home[free_idx] <= fill_home[AW-1:0];
                                r_order[r_held[SW-1:0]] <= MW'(free_idx);
                                r_held <= r_held + 1'b1;
                                if (r_held + 1'b1 >= FULL) r_refill <= 1'b0;
                            end
                        end else if (r_spill) begin
                            if (!sp_found) begin
                                r_spill <= 1'b0;
                                r_cursor_none <= 1'b1;
                            end else begin
                                r_cursor <= sp_depth;
                                r_cursor_none <= 1'b0;
                                r_clean[r_order[sp_depth[SW-1:0]][SW-1:0]] <= 1'b1;
                            end
                        end
                    end
                end
                stc_pkg::S_FILL_WAIT: begin
                    r_word[r_fill_slot] <= m_rdata;
                end
                default: ;
            endcase
            if (r_state == stc_pkg::S_OUT && !i_stall) r_outv <= 1'b0;
            else if (n_state == stc_pkg::S_OUT) r_outv <= 1'b1;
        end
    end

    `STC_ASSERT_IMPL(a_held_le_count, i_clk, i_rst_n, (CW'(r_held) <= r_count),
        "held exceeds depth")
    `STC_ASSERT_IMPL(a_held_le_slots, i_clk, i_rst_n, (r_held <= FULL),
        "held exceeds slots")
    `STC_ASSERT_IMPL(a_one_engine, i_clk, i_rst_n, (!(r_spill && r_refill)),
        "spill and refill both pending")
    `STC_ASSERT_IMPL(a_outv_state, i_clk, i_rst_n,
        (o_valid |-> r_state == stc_pkg::S_OUT), "result outside output state")
endmodule
`default_nettype wire

FILE: bench/stack_cache_checker.sv
`timescale 1ns / 1ps
module stack_cache_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic [2:0]  i_kind,
    input  logic [31:0] i_value,
    input  logic [2:0]  i_reg_sel,
    input  logic [2:0]  i_reg_src,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [31:0] o_read_value,
    input  logic [31:0] o_top_value,
    input  logic [8:0]  o_depth,
    input  logic [3:0]  o_held,
    input  logic [1:0]  o_status,
    output int          fails,
    output int          waiting,
    output int          checked
);
    typedef struct {
        logic [31:0] rd;
        logic [31:0] top;
        logic [8:0]  depth;
        logic [3:0]  held;
        logic [1:0]  status;
    } t_cache_result;

    localparam int NoSlot = stc_pkg::CacheSlots;

    logic [31:0]   slot_word [stc_pkg::CacheSlots];
    bit            slot_live [stc_pkg::CacheSlots];
    bit            slot_clean [stc_pkg::CacheSlots];
    int            slot_home [stc_pkg::CacheSlots];
    int            depth_slot [stc_pkg::CacheSlots];
    int            held_cnt;
    int            stack_cnt;
    int            spill_at;
    bit            spill_on;
    bit            refill_on;
    logic [31:0]   backing [stc_pkg::StackWords];
    t_cache_result pending_results[$];

    function automatic void clear_cache();
        for (int i = 0; i < stc_pkg::CacheSlots; i++) begin
            slot_word[i] = '0;
            slot_live[i] = 0;
            slot_clean[i] = 0;
            slot_home[i] = 0;
            depth_slot[i] = NoSlot;
        end
        for (int i = 0; i < stc_pkg::StackWords; i++) backing[i] = '0;
        held_cnt = 0;
        stack_cnt = 0;
        spill_at = -1;
        spill_on = 0;
        refill_on = 0;
    endfunction

    function automatic int free_slot();
        for (int i = held_cnt + 1; i < stc_pkg::CacheSlots; i++)
            if (!slot_live[i]) return i;
        for (int i = 0; i <= held_cnt && i < stc_pkg::CacheSlots; i++)
            if (!slot_live[i]) return i;
        return 0;
    endfunction

    function automatic void write_back(int s);
        if (slot_home[s] < stc_pkg::StackWords) backing[slot_home[s]] = slot_word[s];
        slot_clean[s] = 1;
    endfunction

    function automatic void spill_one();
        int found;
        found = -1;
        if (spill_at == -1) spill_at = held_cnt - 1;
        for (int i = spill_at; i >= 0; i--) begin
            if (i >= stc_pkg::CacheSlots || i >= held_cnt) continue;
            if (depth_slot[i] < stc_pkg::CacheSlots && slot_live[depth_slot[i]]
                    && !slot_clean[depth_slot[i]]) begin
                found = i;
                break;
            end
        end
        if (found < 0) begin
            spill_on = 0;
            spill_at = -1;
        end else begin
            spill_at = found;
            write_back(depth_slot[found]);
        end
    endfunction

    function automatic void refill_one();
        int s;
        int addr;
        if (held_cnt >= stc_pkg::CacheSlots || stack_cnt <= held_cnt) begin
            refill_on = 0;
            return;
        end
        s = free_slot();
        addr = stack_cnt - held_cnt - 1;
        slot_live[s] = 1;
        slot_clean[s] = 1;
        slot_home[s] = addr;
        slot_word[s] = (addr < stc_pkg::StackWords) ? backing[addr] : '0;
        depth_slot[held_cnt] = s;
        held_cnt++;
        if (held_cnt >= stc_pkg::CacheSlots) refill_on = 0;
    endfunction

    function automatic void background_step();
        if (refill_on) refill_one();
        else if (spill_on) spill_one();
    endfunction

    function automatic stc_pkg::t_status push_word(logic [31:0] v);
        int fr;
        int tp;
        int bot;
        if (stack_cnt >= stc_pkg::StackWords) return stc_pkg::ST_OVERFLOW;
        bot = depth_slot[stc_pkg::CacheSlots-1];
        if (bot < stc_pkg::CacheSlots && !slot_clean[bot]) begin
            for (int i = 0; i < stc_pkg::CacheSlots; i++)
                if (slot_live[i] && !slot_clean[i]) write_back(i);
        end
        if (stc_pkg::SpillMark < stc_pkg::CacheSlots &&
                depth_slot[stc_pkg::SpillMark] != NoSlot) begin
            spill_on = 1;
            refill_on = 0;
        end
        if (held_cnt >= stc_pkg::CacheSlots) begin
            fr = depth_slot[stc_pkg::CacheSlots-1];
            if (fr >= stc_pkg::CacheSlots) fr = 0;
            tp = stc_pkg::CacheSlots - 1;
        end else begin
            fr = free_slot();
            held_cnt++;
            tp = held_cnt - 1;
        end
        for (int i = tp; i >= 1; i--) depth_slot[i] = depth_slot[i-1];
        slot_home[fr] = stack_cnt;
        stack_cnt++;
        depth_slot[0] = fr;
        slot_word[fr] = v;
        slot_clean[fr] = 0;
        slot_live[fr] = 1;
        background_step();
        return stc_pkg::ST_OK;
    endfunction

    function automatic stc_pkg::t_status pop_word();
        int fr;
        if (stack_cnt == 0 || held_cnt == 0) return stc_pkg::ST_UNDERFLOW;
        fr = depth_slot[0];
        for (int i = 0; i + 1 < held_cnt; i++) depth_slot[i] = depth_slot[i+1];
        depth_slot[held_cnt-1] = NoSlot;
        held_cnt--;
        stack_cnt--;
        if (held_cnt <= stc_pkg::RefillMark && stack_cnt != held_cnt) begin
            refill_on = 1;
            spill_on = 0;
        end
        if (spill_on) spill_at = held_cnt - 1;
        if (fr < stc_pkg::CacheSlots) begin
            slot_live[fr] = 0;
            slot_clean[fr] = 0;
        end
        background_step();
        return stc_pkg::ST_OK;
    endfunction

    function automatic int slot_by_depth(int d);
        if (d >= held_cnt || d >= stc_pkg::CacheSlots) return -1;
        if (depth_slot[d] >= stc_pkg::CacheSlots) return -1;
        return depth_slot[d];
    endfunction

    function automatic t_cache_result apply_op(logic [2:0] k, logic [31:0] v,
                                               logic [2:0] sel, logic [2:0] src);
        t_cache_result r;
        int d;
        int s;
        r.rd = '0;
        r.status = stc_pkg::ST_OK;
        case (k)
            stc_pkg::K_PUSH: r.status = push_word(v);
            stc_pkg::K_POP:  r.status = pop_word();
            stc_pkg::K_NOP:  background_step();
            stc_pkg::K_READ: begin
                d = slot_by_depth(sel);
                if (d < 0) r.status = stc_pkg::ST_NOT_HELD;
                else r.rd = slot_word[d];
            end
            stc_pkg::K_WRITE: begin
                d = slot_by_depth(sel);
                if (d < 0) r.status = stc_pkg::ST_NOT_HELD;
                else begin
                    slot_word[d] = v;
                    slot_clean[d] = 0;
                    slot_live[d] = 1;
                end
            end
            stc_pkg::K_MOVE: begin
                d = slot_by_depth(sel);
                s = slot_by_depth(src);
                if (d < 0 || s < 0) r.status = stc_pkg::ST_NOT_HELD;
                else begin
                    slot_word[d] = slot_word[s];
                    slot_clean[d] = 0;
                    slot_live[d] = 1;
                end
            end
            default: ;
        endcase
        d = slot_by_depth(0);
        r.top = (d < 0) ? '0 : slot_word[d];
        r.depth = stack_cnt[8:0];
        r.held = held_cnt[3:0];
        return r;
    endfunction

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $time, field, got, want);
        fails++;
    endtask

    always @(posedge i_clk) begin
        t_cache_result want;
        if (!i_rst_n) begin
            clear_cache();
            pending_results.delete();
            fails = 0;
            checked = 0;
            waiting = 0;
        end else begin
            if (o_valid && !i_stall) begin
                checked++;
                if (pending_results.size() == 0) begin
                    $display("%0t: result beat with nothing outstanding", $time);
                    fails++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_read_value !== want.rd) report("read_value", o_read_value, want.rd);
                    if (o_top_value !== want.top) report("top_value", o_top_value, want.top);
                    if (o_depth !== want.depth) report("depth", o_depth, want.depth);
                    if (o_held !== want.held) report("held", o_held, want.held);
                    if (o_status !== want.status) report("status", o_status, want.status);
                end
            end
            if (i_valid && !o_stall)
                pending_results.push_back(apply_op(i_kind, i_value, i_reg_sel, i_reg_src));
            waiting = pending_results.size();
        end
    end
endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_kind;
    logic [31:0] i_value;
    logic [2:0]  i_reg_sel;
    logic [2:0]  i_reg_src;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_read_value;
    logic [31:0] o_top_value;
    logic [8:0]  o_depth;
    logic [3:0]  o_held;
    logic [1:0]  o_status;

    int fails;
    int waiting;
    int checked;
    int ops_taken;
    int results_taken;
    bit calm;
    bit hold_req;

    stack_top_register_cache DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_kind       (i_kind),
        .i_value      (i_value),
        .i_reg_sel    (i_reg_sel),
        .i_reg_src    (i_reg_src),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_read_value (o_read_value),
        .o_top_value  (o_top_value),
        .o_depth      (o_depth),
        .o_held       (o_held),
        .o_status     (o_status)
    );

    stack_cache_checker u_checker (.*);

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ops_taken <= 0;
            results_taken <= 0;
        end else begin
            if (i_valid && !o_stall) ops_taken <= ops_taken + 1;
            if (o_valid && !i_stall) results_taken <= results_taken + 1;
        end
    end

    // receiver: random back-pressure per beat unless calm, one long hold on request
    initial begin
        int n;
        int tgt;
        bit hold_done;
        hold_done = 0;
        i_stall = 1;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                n = 300;
                hold_done = 1;
            end else begin
                n = calm ? 0 : $urandom_range(0, 16);
            end
            i_stall = 1;
            repeat (n) @(negedge i_clk);
            i_stall = 0;
            tgt = results_taken + 1;
            while (results_taken < tgt) @(negedge i_clk);
            i_stall = !calm && $urandom_range(0, 1);
        end
    end

    task automatic send_op(logic [2:0] k, logic [31:0] v, logic [2:0] sel,
                           logic [2:0] src);
        int gap;
        int tgt;
        gap = calm ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_valid = 0;
            repeat (gap) @(negedge i_clk);
        end
        i_kind = k;
        i_value = v;
        i_reg_sel = sel;
        i_reg_src = src;
        i_valid = 1;
        tgt = ops_taken + 1;
        do @(negedge i_clk); while (ops_taken < tgt);
    endtask

    // push_pct / pop_pct steer the stack size; the rest is slot traffic and noise
    task automatic random_ops(int count, int push_pct, int pop_pct);
        int r;
        logic [2:0] k;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < push_pct) k = stc_pkg::K_PUSH;
            else if (r < push_pct + pop_pct) k = stc_pkg::K_POP;
            else begin
                case ($urandom_range(0, 9))
                    0, 1:    k = stc_pkg::K_NOP;
                    2, 3:    k = stc_pkg::K_READ;
                    4, 5, 6: k = stc_pkg::K_WRITE;
                    7, 8:    k = stc_pkg::K_MOVE;
                    default: k = 3'($urandom_range(6, 7));
                endcase
            end
            send_op(k, $urandom, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
        end
    endtask

    initial begin
        i_rst_n = 0;
        i_valid = 0;
        i_kind = stc_pkg::K_NOP;
        i_value = '0;
        i_reg_sel = '0;
        i_reg_src = '0;
        calm = 0;
        hold_req = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1;

        // empty stack: underflow, slot not held, unknown kinds; then pushes past the cache, slot ops, pops
        send_op(stc_pkg::K_POP, '0, 0, 0);
        send_op(stc_pkg::K_READ, '0, 0, 0);
        send_op(stc_pkg::K_MOVE, '0, 1, 0);
        send_op(3'd6, 32'hffff_ffff, 7, 7);
        send_op(3'd7, '0, 0, 0);
        send_op(stc_pkg::K_NOP, '0, 0, 0);
        send_op(stc_pkg::K_PUSH, 32'h0000_0000, 0, 0);
        send_op(stc_pkg::K_PUSH, 32'hffff_ffff, 0, 0);
        for (int i = 0; i < 8; i++) send_op(stc_pkg::K_PUSH, 32'h1000 + i, 0, 0);
        send_op(stc_pkg::K_READ, '0, 7, 0);
        send_op(stc_pkg::K_WRITE, 32'hdead_beef, 7, 0);
        send_op(stc_pkg::K_MOVE, '0, 0, 7);
        send_op(stc_pkg::K_WRITE, 32'h5555_aaaa, 0, 0);
        for (int i = 0; i < 5; i++) send_op(stc_pkg::K_POP, '0, 0, 0);

        random_ops(100, 30, 25);
        hold_req = 1;
        random_ops(60, 40, 30);
        calm = 1;
        random_ops(60, 35, 30);
        calm = 0;
        random_ops(300, 85, 5);   // climbs to full and overflows
        calm = 1;
        random_ops(40, 50, 10);
        calm = 0;
        random_ops(330, 5, 85);   // drains through refills to underflow
        random_ops(40, 30, 30);

        i_valid = 0;
        while (waiting != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        $display("%0d operations sent, %0d results checked", ops_taken, checked);
        $display("stack driven from empty to full and back, with slot reads, writes, moves");
        if (fails == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", fails);
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

FILE: stack_top_register_cache.f
+incdir+design
design/stc_pkg.sv
design/stc_ram.sv
design/stack_top_register_cache.sv
bench/stack_cache_checker.sv
bench/testbench.sv
